### hw/rtl/lpht_pkg.sv
// Shared types and constants for the linear-probing hash table.
// No dependencies.
package lpht_pkg;
    localparam int TableDepth = 1024;
    localparam int IdxW = $clog2(TableDepth);
    localparam int SizeW = 11;
    localparam int CountW = 11;
    localparam int KeyBytes = 8;
    localparam logic [31:0] HashMult = 32'd31;
    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_UNDEF  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_FULL  = 2'd1,
        ST_TOMB  = 2'd2
    } slot_st_t;

    // A slot as stored: status, key and payload in one memory word.
    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] key;
        logic [63:0] payload;
    } slot_t;

    localparam int SlotW = $bits(slot_t);
endpackage

### hw/rtl/linear_probe_hash_table.sv
// Linear-probing hash table top level: config port, probe sequencer, slot RAM.
// Per item: key hashing byte by byte, then hash mod size bit-serially, a handoff, then
// a read state and a compare/write state per probed slot, at most table_size+1 slots
// (size clamped to 1..TableDepth); m_tvalid rises after the last. One item at a time:
// the next is taken only after m_tready accepts the result. After reset a clearing pass
// marks all TableDepth slots empty before the first item. Depends on lpht_pkg, lpht_ram, lpht_hash.
module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode [1:0], key [65:2], payload_in [129:66], zero fill to 136
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // success [0], payload_out [64:1], key_hash [96:65], home_index [106:97],
    // used_index [117:107], probe_length [128:118], zero fill to 136
    output logic [135:0] m_tdata
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_HASH, S_READ, S_EVAL, S_OUT
    } state_t;

    state_t             state_reg;
    logic [SizeW-1:0]   size_reg;
    logic [CountW-1:0]  count_reg;
    logic [IdxW-1:0]    clr_reg;
    opcode_t            op_reg;
    logic [63:0]        pay_in_reg;
    logic [IdxW-1:0]    idx_reg;
    logic [SizeW-1:0]   k_reg;
    logic [SizeW-1:0]   n_reg;
    logic               ok_reg;
    logic [63:0]        pay_out_reg;
    logic [10:0]        used_reg;
    logic [10:0]        len_reg;

    logic               hash_start, hash_done;
    logic [63:0]        key_c;
    logic [31:0]        hash;
    logic [IdxW-1:0]    home;
    logic [SizeW-1:0]   n_eff;

    logic               ram_we;
    logic [IdxW-1:0]    ram_addr;
    slot_t              ram_wdata, rd;
    logic [IdxW-1:0]    idx_inc;
    logic               hit;

    assign pready   = 1'b1;
    assign prdata   = {21'd0, size_reg};
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {7'd0, len_reg, used_reg, home, hash, pay_out_reg, ok_reg};

    always_comb begin
        n_eff = size_reg;
        if (size_reg == '0) begin
            n_eff = SizeW'(1);
        end else if (size_reg > SizeW'(TableDepth)) begin
            n_eff = SizeW'(TableDepth);
        end
    end

    assign hash_start = (state_reg == S_IDLE) && s_tvalid;

    lpht_hash u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (hash_start),
        .key_raw   (s_tdata[65:2]),
        .size      (n_eff),
        .done      (hash_done),
        .key_canon (key_c),
        .hash      (hash),
        .home      (home)
    );

    assign hit     = (rd.status == ST_FULL) && (rd.key == key_c);
    assign idx_inc = ({1'b0, idx_reg} + 1'b1 >= (IdxW+1)'(n_reg)) ? '0 : idx_reg + 1'b1;

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = idx_reg;
        ram_wdata = '{status: ST_EMPTY, key: key_c, payload: pay_in_reg};
        if (state_reg == S_CLEAR) begin
            ram_we   = 1'b1;
            ram_addr = clr_reg;
        end else if (state_reg == S_EVAL && !hit) begin
            if (op_reg == OP_INSERT && rd.status != ST_FULL && k_reg < n_reg) begin
                ram_we           = 1'b1;
                ram_wdata.status = ST_FULL;
            end
        end else if (state_reg == S_EVAL && hit && op_reg == OP_REMOVE) begin
            ram_we    = 1'b1;
            ram_wdata = '{status: ST_TOMB, key: rd.key, payload: rd.payload};
        end
    end

    lpht_ram #(.Width(SlotW), .Depth(TableDepth)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            size_reg  <= SizeW'(TableDepth);
            count_reg <= '0;
        end else begin
            if (psel && penable && pwrite && paddr == 2'd0) begin
                size_reg <= pwdata[SizeW-1:0];
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == IdxW'(TableDepth - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg     <= opcode_t'(s_tdata[1:0]);
                        pay_in_reg <= s_tdata[129:66];
                        n_reg      <= n_eff;
                        state_reg  <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        idx_reg     <= home;
                        k_reg       <= '0;
                        ok_reg      <= 1'b0;
                        pay_out_reg <= '0;
                        used_reg    <= {1'b0, home};
                        if (op_reg == OP_UNDEF) begin
                            len_reg   <= '0;
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ: state_reg <= S_EVAL;
                S_EVAL: begin
                    state_reg <= S_READ;
                    idx_reg   <= idx_inc;
                    k_reg     <= k_reg + 1'b1;
                    priority if (op_reg == OP_LOOKUP) begin
                        if (k_reg == '0 && count_reg == '0 && rd.status == ST_EMPTY) begin
                            used_reg <= '1; len_reg <= 11'd1; state_reg <= S_OUT;
                        end else if (hit) begin
                            ok_reg <= 1'b1; pay_out_reg <= rd.payload;
                            used_reg <= {1'b0, idx_reg}; len_reg <= k_reg + 1'b1;
                            state_reg <= S_OUT;
                        end else if (k_reg == '0 && rd.status == ST_TOMB
                                     && rd.key == key_c) begin
                            used_reg <= '1; len_reg <= 11'd2; state_reg <= S_OUT;
                        end else if (k_reg == n_reg) begin
                            used_reg <= '1; len_reg <= n_reg + 1'b1; state_reg <= S_OUT;
                        end
                    end else if (op_reg == OP_INSERT) begin
                        if (k_reg == n_reg) begin
                            len_reg <= n_reg; state_reg <= S_OUT;
                        end else if (hit) begin
                            len_reg <= k_reg; state_reg <= S_OUT;
                        end else if (rd.status != ST_FULL) begin
                            ok_reg <= 1'b1; used_reg <= {1'b0, idx_reg};
                            len_reg <= k_reg + 1'b1; state_reg <= S_OUT;
                            if (count_reg != CountMax) count_reg <= count_reg + 1'b1;
                        end
                    end else begin
                        if (hit) begin
                            ok_reg <= 1'b1; pay_out_reg <= rd.payload;
                            used_reg <= {1'b0, idx_reg}; len_reg <= k_reg + 1'b1;
                            state_reg <= S_OUT;
                            if (count_reg != '0) count_reg <= count_reg - 1'b1;
                        end else if (k_reg == n_reg) begin
                            len_reg <= n_reg + 1'b1; state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (m_tready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### hw/rtl/lpht_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module lpht_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### hw/rtl/lpht_hash.sv
// Key hashing unit: one key byte per cycle, then home = hash mod size by
// restoring subtraction, one bit per cycle. Depends on lpht_pkg.
module lpht_hash
    import lpht_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [63:0]      key_raw,
    input  logic [SizeW-1:0] size,
    output logic             done,
    output logic [63:0]      key_canon,
    output logic [31:0]      hash,
    output logic [IdxW-1:0]  home
);
    typedef enum logic [1:0] {H_IDLE, H_BYTE, H_MOD, H_DONE} hstate_t;

    hstate_t                  state_reg;
    logic [3:0]               cnt_reg;
    logic [5:0]               bit_reg;
    logic [63:0]              raw_reg;
    logic                     stop_reg;
    logic [32:0]              rem_reg;
    logic [7:0]               c;
    logic [32:0]              trial;

    assign c     = raw_reg[63:56];
    assign trial = {rem_reg[31:0], hash[bit_reg[4:0]]};
    assign done  = (state_reg == H_DONE);
    assign home  = rem_reg[IdxW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
        end else begin
            unique case (state_reg)
                H_IDLE: begin
                    if (start) begin
                        state_reg <= H_BYTE;
                        cnt_reg   <= '0;
                        raw_reg   <= key_raw;
                        stop_reg  <= 1'b0;
                        hash      <= '0;
                        key_canon <= '0;
                    end
                end
                H_BYTE: begin
                    if (!stop_reg && c != 8'd0) begin
                        hash <= hash * HashMult + {24'd0, c};
                        key_canon[6'(56 - 8 * int'(cnt_reg))+:8] <= c;
                    end else begin
                        stop_reg <= 1'b1;
                    end
                    raw_reg <= {raw_reg[55:0], 8'd0};
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'(KeyBytes - 1)) begin
                        state_reg <= H_MOD;
                        bit_reg   <= 6'd31;
                        rem_reg   <= '0;
                    end
                end
                H_MOD: begin
                    // Restoring remainder, most significant hash bit first.
                    if (trial >= {22'd0, size}) begin
                        rem_reg <= trial - {22'd0, size};
                    end else begin
                        rem_reg <= trial;
                    end
                    bit_reg <= bit_reg - 6'd1;
                    if (bit_reg == 6'd0) begin
                        state_reg <= H_DONE;
                    end
                end
                H_DONE: state_reg <= H_IDLE;
                default: state_reg <= H_IDLE;
            endcase
        end
    end
endmodule

### dv/tb.sv
// Self-checking bench for linear_probe_hash_table: directed table, then random phases
// over several table sizes, each result checked against the typed row's expected value
// or a behavioral predictor. Depends on lpht_pkg and the RTL of linear_probe_hash_table.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lpht_pkg::*;

    localparam logic [1:0] ADDR_TABLE_SIZE = 2'd0;
    localparam logic [10:0] USED_NONE = 11'h7FF;
    localparam logic [63:0] KEY_A = 64'h4100_0000_0000_0000;
    localparam logic [63:0] KEY_A_TAIL = 64'h4100_4200_0000_0000;
    localparam logic [63:0] PAY_A = 64'hDEAD_BEEF_0123_4567;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        success;
        logic [63:0] payload;
        logic [31:0] key_hash;
        logic [9:0]  home;
        logic [10:0] used;
        logic [10:0] probe_len;
    } lookup_result_t;

    typedef struct packed {
        logic [1:0]     op;
        logic [63:0]    key;
        logic [63:0]    pay;
        logic           typed;
        lookup_result_t want;
    } stim_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;

    linear_probe_hash_table dut (.*);

    always #5 aclk = ~aclk;

    // Shadow of the table as the block should hold it.
    slot_st_t     shadow_status [TableDepth];
    logic [63:0]  shadow_key [TableDepth];
    logic [63:0]  shadow_pay [TableDepth];
    int unsigned  shadow_count;
    logic [10:0]  shadow_size;

    lookup_result_t pending_results[$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned items_sent = 0;
    int unsigned hits_seen = 0;
    bit send_idle = 1'b0;
    bit recv_idle = 1'b0;
    int unsigned recv_hold_cycles = 0;

    function automatic logic [63:0] canonical_key(input logic [63:0] raw,
                                                  output logic [31:0] h);
        logic [63:0] k;
        logic [7:0] c;
        bit ended;
        k = '0;
        h = '0;
        ended = 1'b0;
        for (int i = 0; i < KeyBytes; i++) begin
            c = raw[63-8*i -: 8];
            if (c == 8'd0) ended = 1'b1;
            if (!ended) begin
                h = h * HashMult + {24'd0, c};
                k[63-8*i -: 8] = c;
            end
        end
        return k;
    endfunction

    function automatic lookup_result_t predict_table_op(input logic [1:0] op,
                                                       input logic [63:0] raw_key,
                                                       input logic [63:0] pay_in);
        lookup_result_t r;
        logic [63:0] k;
        logic [31:0] h;
        int unsigned n, home, idx;
        k = canonical_key(raw_key, h);
        n = (shadow_size == 0) ? 1 : (shadow_size > TableDepth) ? TableDepth : shadow_size;
        home = h % n;
        r = '0;
        r.key_hash = h;
        r.home = home[9:0];
        r.used = home[10:0];
        case (opcode_t'(op))
            OP_LOOKUP: begin
                if (shadow_count == 0 && shadow_status[home] == ST_EMPTY) begin
                    r.used = USED_NONE;
                    r.probe_len = 11'd1;
                end else if (shadow_status[home] == ST_FULL && shadow_key[home] == k) begin
                    r.success = 1'b1;
                    r.probe_len = 11'd1;
                    r.payload = shadow_pay[home];
                end else if (shadow_status[home] == ST_TOMB && shadow_key[home] == k) begin
                    r.used = USED_NONE;
                    r.probe_len = 11'd2;
                end else begin
                    r.used = USED_NONE;
                    r.probe_len = 11'(n + 1);
                    for (int j = 0; j <= n; j++) begin
                        idx = (home + j) % n;
                        if (shadow_status[idx] == ST_FULL && shadow_key[idx] == k) begin
                            r.success = 1'b1;
                            r.used = idx[10:0];
                            r.probe_len = 11'(j + 1);
                            r.payload = shadow_pay[idx];
                            break;
                        end
                    end
                end
            end
            OP_INSERT: begin
                r.probe_len = 11'(n);
                for (int j = 0; j < n; j++) begin
                    idx = (home + j) % n;
                    if (shadow_status[idx] == ST_FULL && shadow_key[idx] == k) begin
                        r.probe_len = 11'(j);
                        break;
                    end
                    if (shadow_status[idx] != ST_FULL) begin
                        shadow_status[idx] = ST_FULL;
                        shadow_key[idx] = k;
                        shadow_pay[idx] = pay_in;
                        if (shadow_count < CountMax) shadow_count++;
                        r.success = 1'b1;
                        r.used = idx[10:0];
                        r.probe_len = 11'(j + 1);
                        break;
                    end
                end
            end
            OP_REMOVE: begin
                r.probe_len = 11'(n + 1);
                for (int j = 0; j <= n; j++) begin
                    idx = (home + j) % n;
                    if (shadow_status[idx] == ST_FULL && shadow_key[idx] == k) begin
                        shadow_status[idx] = ST_TOMB;
                        if (shadow_count > 0) shadow_count--;
                        r.success = 1'b1;
                        r.used = idx[10:0];
                        r.probe_len = 11'(j + 1);
                        r.payload = shadow_pay[idx];
                        break;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Random symbol: up to eight nonzero bytes, sometimes with junk after the terminator.
    function automatic logic [63:0] random_symbol();
        logic [63:0] k;
        int unsigned n;
        k = '0;
        n = $urandom_range(0, 8);
        for (int i = 0; i < 8; i++) begin
            if (i < n) k[63-8*i -: 8] = 8'($urandom_range(1, 255));
            else if (i > n && $urandom_range(0, 7) == 0) k[63-8*i -: 8] = 8'($urandom);
        end
        return k;
    endfunction

    task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_TABLE_SIZE) shadow_size = data[10:0];
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [1:0] addr, input logic [10:0] want);
        psel <= 1'b1;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[10:0] !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table_size readback: expected %0d, got %0d", want, prdata[10:0]);
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic [1:0] op, input logic [63:0] key,
                             input logic [63:0] pay, input logic typed,
                             input lookup_result_t want);
        int unsigned gap;
        lookup_result_t predicted;
        gap = (send_idle && $urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, pay, key, op};
        do @(posedge aclk); while (!s_tready);
        predicted = predict_table_op(op, key, pay);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    // Result checking at the rising edge.
    always @(posedge aclk) begin
        lookup_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[0], m_tdata[64:1], m_tdata[96:65], m_tdata[106:97],
                   m_tdata[117:107], m_tdata[128:118]};
            results_seen++;
            if (got.success) hits_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item: %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch\n  expected ok=%b pay=%h hash=%h %s",
                                 want.success, want.payload, want.key_hash,
                                 $sformatf("home=%0d used=%h len=%0d",
                                           want.home, want.used, want.probe_len));
                        $display("  actual   ok=%b pay=%h hash=%h home=%0d used=%h len=%0d",
                                 got.success, got.payload, got.key_hash, got.home,
                                 got.used, got.probe_len);
                    end
                end
            end
        end
    end

    // Receiver back-pressure, with one long hold on request.
    initial begin
        forever begin
            @(negedge aclk);
            if (recv_hold_cycles > 0) begin
                m_tready <= 1'b0;
                recv_hold_cycles--;
            end else if (recv_idle && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #40ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        stim_row_t rows[16];
        int unsigned phase_size[11];
        int unsigned phase_items[11];
        logic [63:0] key_pool[$];
        int unsigned pool_n, r;
        logic [1:0] op;
        logic [63:0] key;

        rows = '{
            '{OP_LOOKUP, 64'd0, 64'd0, 1'b1, '{1'b0, 64'd0, 32'd0, 10'd0, USED_NONE, 11'd1}},
            '{OP_INSERT, KEY_A, PAY_A, 1'b1, '{1'b1, 64'd0, 32'd65, 10'd65, 11'd65, 11'd1}},
            '{OP_LOOKUP, KEY_A, 64'd0, 1'b1, '{1'b1, PAY_A, 32'd65, 10'd65, 11'd65, 11'd1}},
            // Bytes after the first zero byte do not count, so this duplicates "A".
            '{OP_INSERT, KEY_A_TAIL, 64'd7, 1'b1,
              '{1'b0, 64'd0, 32'd65, 10'd65, 11'd65, 11'd0}},
            '{OP_UNDEF, KEY_A, ALL_ONES, 1'b1,
              '{1'b0, 64'd0, 32'd65, 10'd65, 11'd65, 11'd0}},
            '{OP_REMOVE, KEY_A, 64'd0, 1'b1, '{1'b1, PAY_A, 32'd65, 10'd65, 11'd65, 11'd1}},
            // Home holds a tombstone of the same key: early miss.
            '{OP_LOOKUP, KEY_A, 64'd0, 1'b1, '{1'b0, 64'd0, 32'd65, 10'd65, USED_NONE, 11'd2}},
            '{OP_INSERT, ALL_ONES, ALL_ONES, 1'b0, '0},
            '{OP_LOOKUP, ALL_ONES, 64'd0, 1'b0, '0},
            '{OP_INSERT, 64'd0, 64'd0, 1'b0, '0},
            '{OP_LOOKUP, 64'd0, 64'd0, 1'b0, '0},
            '{OP_REMOVE, 64'h5A5A_0000_0000_0000, 64'd0, 1'b0, '0},
            '{OP_INSERT, KEY_A, 64'h8000_0000_0000_0001, 1'b0, '0},
            '{OP_LOOKUP, KEY_A, 64'd0, 1'b0, '0},
            '{OP_REMOVE, ALL_ONES, 64'd0, 1'b0, '0},
            '{OP_INSERT, 64'h80FF_7F01_0000_0000, 64'h5555_AAAA_5555_AAAA, 1'b0, '0}
        };
        phase_size = '{1024, 0, 1, 2047, 3, 7, 16, 29, 64, 200, 5};
        phase_items = '{30, 25, 25, 15, 60, 70, 80, 80, 80, 60, 55};

        for (int i = 0; i < TableDepth; i++) begin
            shadow_status[i] = ST_EMPTY;
            shadow_key[i] = '0;
            shadow_pay[i] = '0;
        end
        shadow_count = 0;
        shadow_size = 11'd1024;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        apb_read_check(ADDR_TABLE_SIZE, 11'd1024);
        foreach (rows[i])
            send_item(rows[i].op, rows[i].key, rows[i].pay, rows[i].typed, rows[i].want);
        drain_and_settle();

        // Each phase resizes the table without clearing it, so old entries linger.
        for (int p = 0; p < 11; p++) begin
            apb_write(ADDR_TABLE_SIZE, phase_size[p]);
            apb_read_check(ADDR_TABLE_SIZE, phase_size[p][10:0]);
            send_idle = (p != 10) && ($urandom_range(0, 3) != 0);
            recv_idle = (p != 10) && ($urandom_range(0, 3) != 0);
            if (p == 5) recv_hold_cycles = 3000;
            key_pool.delete();
            pool_n = (phase_size[p] < 2) ? 3 : (phase_size[p] > 16) ? 24 : 2 * phase_size[p] + 2;
            for (int i = 0; i < pool_n; i++) key_pool.push_back(random_symbol());
            for (int i = 0; i < phase_items[p]; i++) begin
                if (p == 6 && i == 40) begin
                    s_tvalid <= 1'b0;
                    while (pending_results.size() != 0) @(negedge aclk);
                    @(negedge aclk);
                end
                r = $urandom_range(0, 99);
                op = (r < 40) ? OP_INSERT : (r < 70) ? OP_LOOKUP : (r < 95) ? OP_REMOVE : OP_UNDEF;
                key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                                  : key_pool[$urandom_range(0, pool_n - 1)];
                send_item(op, key, {$urandom, $urandom}, 1'b0, '0);
            end
            drain_and_settle();
        end

        repeat (50) @(negedge aclk);
        $display("Sent %0d items over 11 table sizes (0, 1, 2047 and 1024 among them);",
                 items_sent);
        $display("checked %0d results, %0d successful, %0d mismatches.",
                 results_seen, hits_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

### sim.f
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_ram.sv
hw/rtl/lpht_hash.sv
hw/rtl/linear_probe_hash_table.sv
dv/tb.sv
